FILE: rtl/core/cgan_pkg.sv
// Shared widths, constants and the queue entry type of the complex Gram average norm block.
package cgan_pkg;

  localparam int unsigned InW           = 16;
  localparam int unsigned ProdW         = 32;
  localparam int unsigned TermW         = 33;
  localparam int unsigned AccW          = 40;
  localparam int unsigned MagW          = 28;
  localparam int unsigned SqW           = 40;
  localparam int unsigned NormW         = 41;
  localparam int unsigned TotalW        = 56;
  localparam int unsigned OutW          = 52;
  localparam int unsigned SlicesDefault = 272;
  localparam int unsigned QueueDepth    = 4;

  typedef struct packed {
    logic [TermW-1:0] re_term;
    logic [TermW-1:0] im_term;
    logic             last_term;
    logic             last_slice;
  } cgan_term_t;

endpackage

FILE: rtl/core/cgan_if.sv
// Valid/ready channel interfaces for the input samples and the averaged result.
interface cgan_in_if import cgan_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] ar_row;
  logic signed [InW-1:0] ai_row;
  logic signed [InW-1:0] ar_col;
  logic signed [InW-1:0] ai_col;
  logic                  last_term;
  logic                  last_slice;

  modport source (output valid, ar_row, ai_row, ar_col, ai_col, last_term, last_slice,
                  input ready);
  modport sink (input valid, ar_row, ai_row, ar_col, ai_col, last_term, last_slice,
                output ready);
endinterface

interface cgan_out_if import cgan_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OutW-1:0] average_norm;

  modport source (output valid, average_norm, input ready);
  modport sink (input valid, average_norm, output ready);
endinterface

FILE: rtl/core/complex_gram_average_norm.sv
// Top level of the complex Gram average norm block.
// Each item is one term of a complex inner product; a four-entry queue behind the product stage
// lets items arrive one per cycle while the accumulator, in its run state, takes one queued
// term per cycle. A term that closes a slice takes the back end through a squaring state and
// then a total update state. A term that closes the final slice, with or without a fold, adds a
// division of the 56-bit total by SLICES (four 14-bit digits, by reciprocal multiplication)
// and a load of the result register; the result waits there until taken. While a second
// result waits behind it the back end stops, the queue fills and the input stalls.
module complex_gram_average_norm import cgan_pkg::*; #(
  parameter int unsigned SLICES = SlicesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  cgan_in_if.sink           in_ch,
  cgan_out_if.source        out_ch
);

  logic       push_valid;
  logic       push_ready;
  cgan_term_t push_data;
  logic       pop_valid;
  logic       pop;
  cgan_term_t pop_data;

  cgan_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .ar_row     (in_ch.ar_row),
    .ai_row     (in_ch.ai_row),
    .ar_col     (in_ch.ar_col),
    .ai_col     (in_ch.ai_col),
    .last_term  (in_ch.last_term),
    .last_slice (in_ch.last_slice),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cgan_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  cgan_back #(
    .SLICES (SLICES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop              (pop),
    .pop_data         (pop_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_average_norm (out_ch.average_norm)
  );

endmodule

FILE: rtl/core/cgan_front.sv
// Front stage: accepts an item, registers its four cross products and forms the complex term.
module cgan_front import cgan_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [InW-1:0] ar_row,
  input  logic signed [InW-1:0] ai_row,
  input  logic signed [InW-1:0] ar_col,
  input  logic signed [InW-1:0] ai_col,
  input  logic                  last_term,
  input  logic                  last_slice,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cgan_term_t            push_data
);

  logic                    stg_valid_r;
  logic                    stg_valid_nxt;
  logic signed [ProdW-1:0] p_rr_r;
  logic signed [ProdW-1:0] p_ii_r;
  logic signed [ProdW-1:0] p_ri_r;
  logic signed [ProdW-1:0] p_ir_r;
  logic                    last_term_r;
  logic                    last_slice_r;
  logic                    accept;
  logic                    push;

  assign in_ready   = !stg_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = stg_valid_r;
  assign push       = stg_valid_r && push_ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = 1'b1;
    end else if (push) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_rr_r       <= ar_row * ar_col;
      p_ii_r       <= ai_row * ai_col;
      p_ri_r       <= ar_row * ai_col;
      p_ir_r       <= ai_row * ar_col;
      last_term_r  <= last_term;
      last_slice_r <= last_slice;
    end
  end

  // The real part is rr + ii and the imaginary part is ri - ir, both exact in 33 bits.
  assign push_data.re_term    = {p_rr_r[ProdW-1], p_rr_r} + {p_ii_r[ProdW-1], p_ii_r};
  assign push_data.im_term    = {p_ri_r[ProdW-1], p_ri_r} - {p_ir_r[ProdW-1], p_ir_r};
  assign push_data.last_term  = last_term_r;
  assign push_data.last_slice = last_slice_r;

endmodule

FILE: rtl/core/cgan_queue.sv
// Short queue of complex terms between the front stage and the accumulator back end.
module cgan_queue import cgan_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  cgan_term_t push_data,
  output logic       pop_valid,
  input  logic       pop,
  output cgan_term_t pop_data
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cgan_term_t          mem_r [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [PtrW-1:0]     rd_ptr_nxt;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     count_nxt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != CntW'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/cgan_back.sv
// Back end: saturating accumulation, per-slice squared magnitude, total and reciprocal division.
module cgan_back import cgan_pkg::*; #(
  parameter int unsigned SLICES = SlicesDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop,
  input  cgan_term_t      pop_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OutW-1:0] out_average_norm
);

  localparam int unsigned DivW     = $clog2(SLICES + 1);
  localparam int unsigned DigW     = 14;
  localparam int unsigned Digits   = TotalW / DigW;
  localparam int unsigned DivSteps = 2 * Digits;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned SlW      = $clog2(SLICES);
  localparam int unsigned RecShift = DigW + 2 * SlW;
  localparam int unsigned RecW     = RecShift - SlW + 2;
  localparam int unsigned DvdW     = DivW + DigW;
  localparam int unsigned PrdW     = DvdW + RecW;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << RecShift) + 64'(SLICES) - 64'd1) / 64'(SLICES));

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SQUARE,
    ST_ADD,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [AccW-1:0]   acc_re_r, acc_re_nxt;
  logic [AccW-1:0]   acc_im_r, acc_im_nxt;
  logic [SqW-1:0]    sq_re_r, sq_re_nxt;
  logic [SqW-1:0]    sq_im_r, sq_im_nxt;
  logic [TotalW-1:0] total_r, total_nxt;
  logic              emit_pend_r, emit_pend_nxt;
  logic [TotalW-1:0] quo_r, quo_nxt;
  logic [DivW-1:0]   rem_r, rem_nxt;
  logic [DigW-1:0]   qd_r, qd_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OutW-1:0]   out_data_r, out_data_nxt;

  logic [AccW:0]     sum_re;
  logic [AccW:0]     sum_im;
  logic [MagW-1:0]   mag_re;
  logic [MagW-1:0]   mag_im;
  logic [2*MagW-1:0] prod_re;
  logic [2*MagW-1:0] prod_im;
  logic [NormW-1:0]  norm;
  logic [TotalW:0]   tsum;
  logic [TotalW-1:0] new_total;
  logic [DvdW-1:0]   dvd;
  logic [PrdW-1:0]   prod_q;
  logic [DvdW-1:0]   qd_mul;
  logic [DvdW-1:0]   rem_full;

  function automatic logic [AccW-1:0] sat_acc(input logic [AccW:0] s);
    logic [AccW-1:0] r;
    if (s[AccW] != s[AccW-1]) begin
      r = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = s[AccW-1:0];
    end
    return r;
  endfunction

  // Magnitude of the accumulator shifted right 12 bits, rounding toward minus infinity.
  function automatic logic [MagW-1:0] scaled_mag(input logic [AccW-1:0] a);
    logic [AccW-1:0] inv;
    logic [MagW-1:0] m;
    inv = ~a;
    if (a[AccW-1]) begin
      m = {1'b0, inv[AccW-2:12]} + MagW'(1);
    end else begin
      m = {1'b0, a[AccW-2:12]};
    end
    return m;
  endfunction

  assign sum_re  = {acc_re_r[AccW-1], acc_re_r}
                 + {{(AccW+1-TermW){pop_data.re_term[TermW-1]}}, pop_data.re_term};
  assign sum_im  = {acc_im_r[AccW-1], acc_im_r}
                 + {{(AccW+1-TermW){pop_data.im_term[TermW-1]}}, pop_data.im_term};
  assign mag_re  = scaled_mag(acc_re_r);
  assign mag_im  = scaled_mag(acc_im_r);
  assign prod_re = mag_re * mag_re;
  assign prod_im = mag_im * mag_im;
  assign norm    = {1'b0, sq_re_r} + {1'b0, sq_im_r};
  assign tsum    = {1'b0, total_r} + {{(TotalW + 1 - NormW){1'b0}}, norm};
  assign new_total = tsum[TotalW] ? {TotalW{1'b1}} : tsum[TotalW-1:0];

  // Long division in 14-bit digits: the reciprocal product gives the quotient digit exactly
  // because the partial dividend stays below SLICES times 2^14.
  assign dvd      = {rem_r, quo_r[TotalW-1 -: DigW]};
  assign prod_q   = PrdW'(dvd) * PrdW'(Recip);
  assign qd_mul   = DvdW'(qd_r) * DvdW'(SLICES);
  assign rem_full = dvd - qd_mul;

  assign pop              = (state_r == ST_RUN) && pop_valid;
  assign out_valid        = out_valid_r;
  assign out_average_norm = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    sq_re_nxt     = sq_re_r;
    sq_im_nxt     = sq_im_r;
    total_nxt     = total_r;
    emit_pend_nxt = emit_pend_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    qd_nxt        = qd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_RUN: begin
        if (pop_valid) begin
          acc_re_nxt = sat_acc(sum_re);
          acc_im_nxt = sat_acc(sum_im);
          if (pop_data.last_term) begin
            emit_pend_nxt = pop_data.last_slice;
            state_nxt     = ST_SQUARE;
          end else if (pop_data.last_slice) begin
            quo_nxt   = total_r;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            total_nxt = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_SQUARE: begin
        sq_re_nxt  = prod_re[2*MagW-1:16];
        sq_im_nxt  = prod_im[2*MagW-1:16];
        acc_re_nxt = '0;
        acc_im_nxt = '0;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        if (emit_pend_r) begin
          quo_nxt   = new_total;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          total_nxt = '0;
          state_nxt = ST_DIV;
        end else begin
          total_nxt = new_total;
          state_nxt = ST_RUN;
        end
      end
      ST_DIV: begin
        if (!cnt_r[0]) begin
          qd_nxt = prod_q[RecShift+DigW-1:RecShift];
        end else begin
          rem_nxt = rem_full[DivW-1:0];
          quo_nxt = {quo_r[TotalW-DigW-1:0], qd_r};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(DivSteps - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (quo_r[TotalW-1:OutW] != '0) ? {OutW{1'b1}} : quo_r[OutW-1:0];
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      total_r     <= '0;
      emit_pend_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_re_r    <= acc_re_nxt;
      acc_im_r    <= acc_im_nxt;
      total_r     <= total_nxt;
      emit_pend_r <= emit_pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_re_r    <= sq_re_nxt;
    sq_im_r    <= sq_im_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    qd_r       <= qd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/cgan_checker.sv
// Port-level assertions for the complex Gram average norm block and their binding.
module cgan_checker import cgan_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [OutW-1:0] out_average_norm
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_average_norm))
    else $error("Result item changed while stalled.");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("Block is not empty and ready after reset.");

endmodule

bind complex_gram_average_norm cgan_checker u_cgan_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_average_norm (out_ch.average_norm)
);

FILE: test/tb_top.sv
// Self-checking bench for complex_gram_average_norm: directed, saturation, random, hold, drain.
module tb_top;
  import cgan_pkg::*;

  localparam int unsigned NumSlices = SlicesDefault;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 100;
  localparam longint AccMax = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin = -(longint'(1) <<< (AccW - 1));
  localparam longint unsigned TotalMax = (64'd1 << TotalW) - 1;
  localparam longint unsigned OutMax = (64'd1 << OutW) - 1;

  typedef struct {
    logic signed [InW-1:0] ar_row;
    logic signed [InW-1:0] ai_row;
    logic signed [InW-1:0] ar_col;
    logic signed [InW-1:0] ai_col;
    bit                    last_term;
    bit                    last_slice;
  } gram_term_t;

  logic clk = 1'b0;
  logic rst_n;

  cgan_in_if  in_ch ();
  cgan_out_if out_ch ();

  complex_gram_average_norm #(.SLICES(NumSlices)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  longint          pend_re;
  longint          pend_im;
  longint unsigned norm_sum;
  logic [OutW-1:0] expected_norms[$];
  int              mismatch_count = 0;
  int              items_sent = 0;
  int              burst_left = 0;
  bit              gaps_on = 1'b1;
  bit              hold_request = 1'b0;
  int              hold_count = 0;
  int              stall_mode = 0;
  int              mode_left = 0;

  function automatic longint clamp_acc(longint v);
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  // Floor shift to Q.16, exact square, then truncate back to Q.16.
  function automatic longint unsigned folded_square(longint acc);
    longint q;
    q = acc >>> 12;
    if (q < 0) q = -q;
    return longint'((q * q) >> 16);
  endfunction

  task automatic apply_term(gram_term_t t);
    longint unsigned norm;
    longint unsigned avg;
    pend_re = clamp_acc(pend_re + longint'(t.ar_row) * longint'(t.ar_col)
                                + longint'(t.ai_row) * longint'(t.ai_col));
    pend_im = clamp_acc(pend_im + longint'(t.ar_row) * longint'(t.ai_col)
                                - longint'(t.ai_row) * longint'(t.ar_col));
    if (t.last_term) begin
      norm = folded_square(pend_re) + folded_square(pend_im);
      norm_sum = (norm > TotalMax - norm_sum) ? TotalMax : norm_sum + norm;
      pend_re = 0;
      pend_im = 0;
    end
    if (t.last_slice) begin
      avg = norm_sum / NumSlices;
      if (avg > OutMax) avg = OutMax;
      expected_norms.push_back(avg[OutW-1:0]);
      norm_sum = 0;
    end
  endtask

  function automatic gram_term_t pack_term(int a, int b, int c, int d, bit lt, bit ls);
    gram_term_t t;
    t.ar_row = a[InW-1:0];
    t.ai_row = b[InW-1:0];
    t.ar_col = c[InW-1:0];
    t.ai_col = d[InW-1:0];
    t.last_term = lt;
    t.last_slice = ls;
    return t;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return int'($urandom_range(0, 16)) - 8;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic gram_term_t make_term(bit lt, bit ls);
    return pack_term(rand_sample(), rand_sample(), rand_sample(), rand_sample(), lt, ls);
  endfunction

  task automatic send_term(gram_term_t t);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.ar_row <= t.ar_row;
    in_ch.ai_row <= t.ai_row;
    in_ch.ar_col <= t.ar_col;
    in_ch.ai_col <= t.ai_col;
    in_ch.last_term <= t.last_term;
    in_ch.last_slice <= t.last_slice;
    do @(posedge clk); while (!in_ch.ready);
    apply_term(t);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_norms.size() != 0) @(posedge clk);
  endtask

  task automatic send_slices(int n_slices, int max_terms);
    int n_terms;
    for (int s = 0; s < n_slices; s++) begin
      n_terms = $urandom_range(1, max_terms);
      for (int k = 0; k < n_terms; k++) begin
        send_term(make_term(k == n_terms - 1, (s == n_slices - 1) && (k == n_terms - 1)));
      end
    end
  endtask

  task automatic test_corner_terms();
    send_term(pack_term(32767, 32767, 32767, 32767, 1, 1));
    send_term(pack_term(-32768, -32768, -32768, -32768, 1, 1));
    send_term(pack_term(-32768, 32767, 32767, -32768, 1, 1));
    send_term(pack_term(0, 0, 0, 0, 1, 1));
    send_term(pack_term(0, 0, 0, 0, 0, 1));
    send_term(pack_term(1000, -2000, 3000, -4000, 0, 0));
    send_term(pack_term(-32768, -32768, -32768, -32768, 1, 0));
    send_term(pack_term(12345, -23456, 7, -1, 1, 0));
    // The open slice stays in the accumulators across an emit without a fold.
    send_term(pack_term(32767, -32768, -32768, 32767, 0, 1));
    send_term(pack_term(5, 6, 7, 8, 1, 1));
    send_term(pack_term(1, 1, 1, 1, 1, 0));
    send_term(pack_term(-1, -1, -1, -1, 1, 1));
    send_term(pack_term(-300, 255, 4095, -4096, 0, 0));
    send_term(pack_term(-32768, 32767, -32768, 32767, 1, 1));
  endtask

  task automatic test_accumulator_saturation();
    gaps_on = 1'b0;
    repeat (257) send_term(pack_term(-32768, -32768, -32768, -32768, 0, 0));
    send_term(pack_term(-32768, -32768, -32768, -32768, 1, 0));
    repeat (257) send_term(pack_term(-32768, -32768, -32768, 32767, 0, 0));
    send_term(pack_term(-32768, -32768, -32768, 32767, 1, 1));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_slices(int n_items);
    int start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) begin
          send_term(make_term($urandom_range(0, 1), $urandom_range(0, 4) == 0));
        end
        1: send_slices($urandom_range(1, 3), 64);
        default: send_slices($urandom_range(1, 4), 8);
      endcase
    end
  endtask

  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (10) send_slices(1, 4);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_slices(3, 6);
    pause_until_drained();
    send_slices(2, 6);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count == HoldCycles) begin
          hold_request = 1'b0;
          hold_count = 0;
        end
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (mode_left % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    logic [OutW-1:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_norms.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected average_norm %0d", out_ch.average_norm);
          end
        end else begin
          want = expected_norms.pop_front();
          if (out_ch.average_norm !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("average_norm mismatch: expected %0d, got %0d", want,
                       out_ch.average_norm);
            end
          end
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    pend_re = 0;
    pend_im = 0;
    norm_sum = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.ar_row <= '0;
    in_ch.ai_row <= '0;
    in_ch.ar_col <= '0;
    in_ch.ai_col <= '0;
    in_ch.last_term <= 1'b0;
    in_ch.last_slice <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_terms();
    test_accumulator_saturation();
    test_random_slices(25);
    test_output_hold();
    test_drain_pause();
    test_random_slices(25);
    pause_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_norms.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cgan_pkg.sv
rtl/core/cgan_if.sv
rtl/core/cgan_front.sv
rtl/core/cgan_queue.sv
rtl/core/cgan_back.sv
rtl/core/complex_gram_average_norm.sv
rtl/core/cgan_checker.sv
test/tb_top.sv
